// ===== rtl/emboss_pixel_filter_defines.svh =====
// Assertion macros used by the checker file of the emboss pixel filter.
`ifndef EMBOSS_PIXEL_FILTER_DEFINES_SVH
`define EMBOSS_PIXEL_FILTER_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define EPF_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("emboss_pixel_filter: assertion failed");

// Clocked assertion on the checker's own clk_i and rst_ni.
`define EPF_ASSERT(lbl, prop) `EPF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/epf_pkg.sv =====
// Package with constants, types and the gray function of the emboss pixel filter.
`default_nettype none

package epf_pkg;

  localparam int MaxWidth  = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = 16;
  localparam int CfgWidthW = 11;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int PixelW    = 32;
  localparam int RgbW      = 24;

  localparam logic [CfgWidthW-1:0] ImageWidthReset  = 11'd1024;
  localparam logic [RowW-1:0]      ImageHeightReset = 16'd1024;
  localparam logic [7:0]           GrayMid          = 8'd128;
  localparam logic [7:0]           GrayMax          = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic            interior;
    logic            last;
  } raster_t;

  function automatic logic signed [8:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
    chan_diff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [8:0] chan_mag(input logic signed [8:0] d);
    chan_mag = d[8] ? 9'(-d) : 9'(d);
  endfunction

  function automatic logic [7:0] emboss_gray(input logic [RgbW-1:0] ul,
                                             input logic [RgbW-1:0] rgb);
    logic signed [8:0] dr;
    logic signed [8:0] dg;
    logic signed [8:0] db;
    logic signed [8:0] d;
    logic signed [9:0] v;
    dr = chan_diff(ul[23:16], rgb[23:16]);
    dg = chan_diff(ul[15:8], rgb[15:8]);
    db = chan_diff(ul[7:0], rgb[7:0]);
    d  = dr;
    if (chan_mag(dg) > chan_mag(d)) d = dg;
    if (chan_mag(db) > chan_mag(d)) d = db;
    v = 10'(d) + $signed({2'b00, GrayMid});
    if (v > $signed({2'b00, GrayMax})) begin
      emboss_gray = GrayMax;
    end else if (v < 0) begin
      emboss_gray = 8'd0;
    end else begin
      emboss_gray = v[7:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/epf_ram.sv =====
// Generic single-port RAM with read-first registered read.
`default_nettype none

module epf_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/epf_raster.sv =====
// Frame size registers and raster position counters of the emboss pixel filter.
`default_nettype none

module epf_raster
  import epf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                advance_i,
  output raster_t                  pos_o
);

  logic [CfgWidthW-1:0] width_q, width_d;
  logic [RowW-1:0]      height_q, height_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [ColW-1:0]      last_col;
  logic [RowW-1:0]      last_row;

  always_comb begin
    if (width_q == '0) begin
      last_col = '0;
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      last_col = ColW'(MaxWidth - 1);
    end else begin
      last_col = ColW'(32'(width_q) - 32'd1);
    end
    last_row = (height_q == '0) ? '0 : height_q - 16'd1;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_d  = cfg_data_i[CfgWidthW-1:0];
        CFG_IMAGE_HEIGHT: height_d = cfg_data_i[RowW-1:0];
        default: ;
      endcase
      col_d = '0;
      row_d = '0;
    end else if (advance_i) begin
      if (col_q == last_col) begin
        col_d = '0;
        row_d = (row_q == last_row) ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImageWidthReset;
      height_q <= ImageHeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign pos_o.col      = col_q;
  assign pos_o.interior = (col_q != '0) && (row_q != '0);
  assign pos_o.last     = (col_q == last_col) && (row_q == last_row);

endmodule

`default_nettype wire

// ===== rtl/emboss_pixel_filter.sv =====
// Top level of the emboss pixel filter: row store, gray datapath and output register.
//
//   channel  direction  signals                              transfer when
//   in       input      in_valid_i, in_ready_o, pixel_in_i   in_valid_i & in_ready_o
//   out      output     out_valid_o, out_ready_i, pixel_out_o, frame_end_o
//                                                            out_valid_o & out_ready_i
//   cfg      input      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//                                                            cfg_valid_i & cfg_ready_o
//
// One pixel per cycle without output stalls; a result appears the next cycle.
// The row store is a single-port RAM read and written at the current column in
// the transfer cycle; its registered read data is the upper-left neighbor.
// The row store is not cleared by reset; reset restores both frame size registers.
// in_ready_o drops only while a result waits and out_ready_i is low.
`default_nettype none

module emboss_pixel_filter
  import epf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [PixelW-1:0]   pixel_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [PixelW-1:0]   pixel_out_o,
  output logic                     frame_end_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic              accept;
  logic              cfg_we;
  raster_t           pos;
  logic [RgbW-1:0]   upper_left;
  logic [7:0]        gray;
  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] pixel_q, pixel_d;
  logic              frame_end_q, frame_end_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  epf_raster u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (accept),
    .pos_o       (pos)
  );

  epf_ram #(
    .Width (RgbW),
    .Depth (MaxWidth)
  ) u_row_store (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (accept),
    .addr_i  (pos.col),
    .wdata_i (pixel_in_i[31:8]),
    .rdata_o (upper_left)
  );

  assign gray = pos.interior ? emboss_gray(upper_left, pixel_in_i[31:8]) : GrayMid;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    pixel_d     = pixel_q;
    frame_end_d = frame_end_q;
    if (accept) begin
      out_valid_d = 1'b1;
      pixel_d     = {gray, gray, gray, pixel_in_i[7:0]};
      frame_end_d = pos.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q     <= pixel_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// ===== rtl/epf_checker.sv =====
// Port-level assertions for the emboss pixel filter and their bind.
`default_nettype none
`include "emboss_pixel_filter_defines.svh"

module epf_checker
  import epf_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic [PixelW-1:0]   pixel_in_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [PixelW-1:0]   pixel_out_o,
  input wire logic                frame_end_o,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o
);

  `EPF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o) && $stable(frame_end_o))
  `EPF_ASSERT(a_alpha_kept, in_valid_i && in_ready_o |=> out_valid_o && (pixel_out_o[7:0] == $past(pixel_in_i[7:0])))
  `EPF_ASSERT(a_gray_bytes, out_valid_o |-> (pixel_out_o[31:24] == pixel_out_o[23:16]) && (pixel_out_o[23:16] == pixel_out_o[15:8]))
  `EPF_ASSERT(a_restart_mid, (cfg_valid_i && cfg_ready_o) ##1 (in_valid_i && in_ready_o) |=> (pixel_out_o[31:8] == {3{GrayMid}}))

endmodule

bind emboss_pixel_filter epf_checker u_epf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .pixel_in_i  (pixel_in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_out_o (pixel_out_o),
  .frame_end_o (frame_end_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the emboss pixel filter with a built-in gray predictor.
module tb;
  import epf_pkg::*;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned RandomItems = 250;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused3 = 2'd3;

  typedef struct {
    logic [PixelW-1:0] pixel;
    logic              frame_end;
  } emboss_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [PixelW-1:0]   pixel_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [PixelW-1:0]   pixel_out_o;
  logic                frame_end_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [CfgWidthW-1:0] width_reg;
  logic [RowW-1:0]      height_reg;
  logic [RgbW-1:0]      line_mem [MaxWidth];
  logic [RgbW-1:0]      ul_hold;
  int unsigned          row_pos;
  int unsigned          col_pos;

  emboss_t     embossed_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned random_items = 0;
  bit          send_gaps_on = 1'b1;
  bit          recv_stalls_on = 1'b1;

  emboss_pixel_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .frame_end_o (frame_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always begin
    @(negedge clk_i);
    if (recv_stalls_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin : check_output
    emboss_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (embossed_q.size() == 0) begin
        $display("%0t unexpected transfer pixel_out %h frame_end %b",
                 $time, pixel_out_o, frame_end_o);
        mismatch_count++;
      end else begin
        want = embossed_q.pop_front();
        if (pixel_out_o !== want.pixel) begin
          $display("%0t pixel_out mismatch exp %h got %h", $time, want.pixel, pixel_out_o);
          mismatch_count++;
        end
        if (frame_end_o !== want.frame_end) begin
          $display("%0t frame_end mismatch exp %b got %b",
                   $time, want.frame_end, frame_end_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic emboss_predict(input logic [PixelW-1:0] px);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned col;
    int unsigned row;
    logic [RgbW-1:0] rgb;
    int dr;
    int dg;
    int db;
    int d;
    int v;
    logic [7:0] gray;
    emboss_t res;
    w_eff = eff_width();
    h_eff = eff_height();
    rgb = px[31:8];
    col = col_pos;
    row = row_pos;
    if (col >= w_eff) col = w_eff - 1;
    if (row >= h_eff) row = h_eff - 1;
    gray = GrayMid;
    if (row != 0 && col != 0) begin
      dr = int'(ul_hold[23:16]) - int'(rgb[23:16]);
      dg = int'(ul_hold[15:8]) - int'(rgb[15:8]);
      db = int'(ul_hold[7:0]) - int'(rgb[7:0]);
      d = dr;
      if (abs_int(dg) > abs_int(d)) d = dg;
      if (abs_int(db) > abs_int(d)) d = db;
      v = d + int'(GrayMid);
      if (v > int'(GrayMax)) v = int'(GrayMax);
      if (v < 0) v = 0;
      gray = v[7:0];
    end
    ul_hold = line_mem[col];
    line_mem[col] = rgb;
    res.pixel = {gray, gray, gray, px[7:0]};
    res.frame_end = (col == w_eff - 1) && (row == h_eff - 1);
    embossed_q.push_back(res);
    if (col + 1 >= w_eff) begin
      col_pos = 0;
      row_pos = (row + 1 >= h_eff) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endtask

  task automatic send_pixel(input logic [PixelW-1:0] px);
    @(negedge clk_i);
    if (send_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    emboss_predict(px);
  endtask

  task automatic flush_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (embossed_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    flush_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_IMAGE_WIDTH) width_reg = data[CfgWidthW-1:0];
    else if (idx == CFG_IMAGE_HEIGHT) height_reg = data;
    row_pos = 0;
    col_pos = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel($urandom());
  endtask

  task automatic test_reset_size();
    send_random(24);
  endtask

  task automatic test_gray_cases();
    logic [PixelW-1:0] px [13];
    px = '{32'hFF00_0000, 32'h0080_80FF, 32'h8080_805A, 32'h1234_5678,
           32'h00FF_00A5, 32'h0000_0001, 32'h324E_80C3, 32'h801C_E43C,
           32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0102_4080, 32'h324E_80FE,
           32'h7F7F_7F7F};
    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    foreach (px[i]) begin
      send_pixel(px[i]);
      if (i == 5) flush_results();
    end
  endtask

  task automatic test_degenerate_sizes();
    write_reg(CFG_IMAGE_WIDTH, 16'h0000);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    send_random(3);
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0000);
    send_random(3);
  endtask

  task automatic test_unused_index();
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    send_random(3);
    write_reg(CfgIdxUnused2, 16'hA5A5);
    send_random(4);
    write_reg(CfgIdxUnused3, 16'h5A5A);
    send_random(1);
  endtask

  task automatic test_wide_frame();
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    send_random(40);
  endtask

  task automatic test_tall_frame();
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    send_random(30);
  endtask

  task automatic test_random_frames();
    int unsigned w_val;
    int unsigned h_val;
    int unsigned frame_px;
    int unsigned count;
    while (random_items < RandomItems) begin
      w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
      h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 5);
      write_reg(CFG_IMAGE_WIDTH, {5'($urandom()), 11'(w_val)});
      case ($urandom_range(0, 5))
        0: write_reg(CfgIdxUnused2, 16'($urandom()));
        1: write_reg(CfgIdxUnused3, 16'($urandom()));
        default: write_reg(CFG_IMAGE_HEIGHT, 16'(h_val));
      endcase
      frame_px = eff_width() * eff_height();
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, frame_px);
      else count = frame_px * $urandom_range(1, 3);
      if (count > 150) count = 150;
      if (count > RandomItems - random_items) count = RandomItems - random_items;
      repeat (count) begin
        send_pixel($urandom());
        random_items++;
        if ($urandom_range(0, 99) == 0) flush_results();
      end
    end
  endtask

  task automatic test_steady_stream();
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b0;
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'd4);
    send_random(60);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pixel_in_i  = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    width_reg   = ImageWidthReset;
    height_reg  = ImageHeightReset;
    ul_hold     = '0;
    row_pos     = 0;
    col_pos     = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_size();
    test_gray_cases();
    test_degenerate_sizes();
    test_unused_index();
    test_wide_frame();
    test_tall_frame();
    test_random_frames();
    test_steady_stream();

    flush_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && embossed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/epf_pkg.sv
rtl/epf_ram.sv
rtl/epf_raster.sv
rtl/emboss_pixel_filter.sv
rtl/epf_checker.sv
test/tb.sv
